// ===== hw/rtl/qrp_pkg.sv =====
// Shared constants for the quaternion point rotation pipeline.
// No dependencies; used by the top level and its submodules.
package qrp_pkg;

   localparam int QUAT_WIDTH = 16;
   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int POINT_WIDTH_DEFAULT = 24;

   // Squared magnitude of four components, and the root digits it yields.
   localparam int MAG2_WIDTH = 2 * QUAT_WIDTH + 1;
   localparam int ROOT_WIDTH = (MAG2_WIDTH + 1) / 2;

endpackage

// ===== hw/rtl/qrp_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Uses qrp_pkg for the radicand and root widths.
module qrp_isqrt (
   input  logic                               clock,
   input  logic                               en,
   input  logic [qrp_pkg::MAG2_WIDTH-1:0]     rad_i,
   output logic [qrp_pkg::ROOT_WIDTH-1:0]     root_o
);

   localparam int NS = qrp_pkg::ROOT_WIDTH;
   localparam int NE = 2 * NS;
   localparam int RW = NS + 3;

   logic [RW-1:0] rem_ff [NS];
   logic [NS-1:0] root_ff [NS];
   logic [NE-1:0] rad_ff [NS];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         logic [RW-1:0] prev_rem;
         logic [NS-1:0] prev_root;
         logic [NE-1:0] prev_rad;
         logic [RW-1:0] rem2;
         logic [RW-1:0] trial;
         logic          ge;
         logic [RW-1:0] rem_in;
         logic [NS-1:0] root_in;
         logic [NE-1:0] rad_in;

         if (k == 0) begin : g_first
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_rad  = NE'(rad_i);
         end else begin : g_next
            assign prev_rem  = rem_ff[k-1];
            assign prev_root = root_ff[k-1];
            assign prev_rad  = rad_ff[k-1];
         end

         always_comb begin
            rem2    = {prev_rem[RW-3:0], prev_rad[NE-1:NE-2]};
            trial   = RW'({prev_root, 2'b01});
            ge      = (rem2 >= trial);
            rem_in  = ge ? (rem2 - trial) : rem2;
            root_in = {prev_root[NS-2:0], ge};
            rad_in  = {prev_rad[NE-3:0], 2'b00};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               rad_ff[k]  <= rad_in;
            end
         end
      end
   endgenerate

   assign root_o = root_ff[NS-1];

endmodule

// ===== hw/rtl/qrp_div_lane.sv =====
// Pipelined restoring divider for one inverse component, one quotient bit per stage.
// Uses qrp_pkg for the magnitude and component widths.
module qrp_div_lane #(
   parameter int FRAC_BITS = qrp_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic [qrp_pkg::ROOT_WIDTH-1:0]        mag_i,
   input  logic [qrp_pkg::QUAT_WIDTH-1:0]        num_i,
   input  logic                                  neg_i,
   output logic signed [FRAC_BITS+1:0]           quot_o
);

   localparam int MW = qrp_pkg::ROOT_WIDTH;
   localparam int ST = FRAC_BITS + 1;

   logic [MW:0]   rem_ff [ST];
   logic [ST-1:0] q_ff [ST];
   logic [MW-1:0] mag_ff [ST];
   logic          neg_ff [ST];

   genvar k;
   generate
      for (k = 0; k < ST; k++) begin : g_stage
         logic [MW:0]   rem2;
         logic [ST-1:0] prev_q;
         logic [MW-1:0] prev_mag;
         logic          prev_neg;
         logic          ge;
         logic [MW:0]   rem_in;

         if (k == 0) begin : g_first
            assign rem2     = (MW+1)'(num_i);
            assign prev_q   = '0;
            assign prev_mag = mag_i;
            assign prev_neg = neg_i;
         end else begin : g_next
            assign rem2     = {rem_ff[k-1][MW-1:0], 1'b0};
            assign prev_q   = q_ff[k-1];
            assign prev_mag = mag_ff[k-1];
            assign prev_neg = neg_ff[k-1];
         end

         always_comb begin
            ge     = (rem2 >= {1'b0, prev_mag});
            rem_in = ge ? (rem2 - {1'b0, prev_mag}) : rem2;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               q_ff[k]   <= {prev_q[ST-2:0], ge};
               mag_ff[k] <= prev_mag;
               neg_ff[k] <= prev_neg;
            end
         end
      end
   endgenerate

   assign quot_o = neg_ff[ST-1] ? -$signed({1'b0, q_ff[ST-1]})
                                :  $signed({1'b0, q_ff[ST-1]});

endmodule

// ===== hw/rtl/quaternion_rotate_point_unit.sv =====
// Quaternion point rotation, fully pipelined with no bubbles: one request per cycle,
// but the whole pipeline holds while a result is stalled. The square root and the
// inverse dividers each resolve one bit per stage.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on qrp_pkg, qrp_isqrt and qrp_div_lane.
module quaternion_rotate_point_unit #(
   parameter int FRAC_BITS   = qrp_pkg::FRAC_BITS_DEFAULT,
   parameter int POINT_WIDTH = qrp_pkg::POINT_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // quat_x, quat_y, quat_z, quat_w, point_x, point_y, point_z, zero fill
   input  logic [((4*qrp_pkg::QUAT_WIDTH+3*POINT_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rot_x, rot_y, rot_z, zero fill
   output logic [((3*POINT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // saturated, zero_quat
   output logic [1:0] rsp_tuser
);

   localparam int QW  = qrp_pkg::QUAT_WIDTH;
   localparam int PW  = POINT_WIDTH;
   localparam int NS  = qrp_pkg::ROOT_WIDTH;
   localparam int DS  = FRAC_BITS + 1;
   localparam int IW  = FRAC_BITS + 2;
   localparam int P1W = QW + PW;
   localparam int S1W = P1W + 2;
   localparam int TW  = S1W - FRAC_BITS;
   localparam int P2W = TW + IW;
   localparam int S2W = P2W + 2;
   localparam int TD  = NS + DS;
   localparam int LAT = 4 + NS + DS;
   localparam int RSP_W = ((3 * PW + 7) / 8) * 8;
   localparam logic signed [S2W-1:0] RHI = S2W'((64'sd1 <<< (PW - 1)) - 64'sd1);
   localparam logic signed [S2W-1:0] RLO = -RHI - S2W'(1);

   logic en;
   logic vld_ff [LAT];

   assign en = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   logic signed [QW-1:0] qx, qy, qz, qw;
   logic signed [PW-1:0] px, py, pz;
   assign qx = req_tdata[0*QW +: QW];
   assign qy = req_tdata[1*QW +: QW];
   assign qz = req_tdata[2*QW +: QW];
   assign qw = req_tdata[3*QW +: QW];
   assign px = req_tdata[4*QW +: PW];
   assign py = req_tdata[4*QW+PW +: PW];
   assign pz = req_tdata[4*QW+2*PW +: PW];

   // Stage A: squares and the products of q * (p, 0).
   logic signed [2*QW-1:0] sq_ff [4];
   logic signed [P1W-1:0]  pr_ff [12];
   logic signed [QW-1:0]   qa_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= qx * qx;
         sq_ff[1] <= qy * qy;
         sq_ff[2] <= qz * qz;
         sq_ff[3] <= qw * qw;
         pr_ff[0]  <= qx * px;
         pr_ff[1]  <= qy * py;
         pr_ff[2]  <= qz * pz;
         pr_ff[3]  <= qw * px;
         pr_ff[4]  <= qy * pz;
         pr_ff[5]  <= qz * py;
         pr_ff[6]  <= qw * py;
         pr_ff[7]  <= qz * px;
         pr_ff[8]  <= qx * pz;
         pr_ff[9]  <= qw * pz;
         pr_ff[10] <= qx * py;
         pr_ff[11] <= qy * px;
         qa_ff[0] <= qx;
         qa_ff[1] <= qy;
         qa_ff[2] <= qz;
         qa_ff[3] <= qw;
      end
   end

   // Stage B: squared magnitude and the four components of t.
   logic [qrp_pkg::MAG2_WIDTH-1:0] mag2_ff;
   logic signed [S1W-1:0] ts_in [4];
   logic signed [TW-1:0]  t_ff [4];
   logic signed [QW-1:0]  qb_ff [4];

   always_comb begin
      ts_in[0] = -S1W'(pr_ff[0]) - S1W'(pr_ff[1]) - S1W'(pr_ff[2]);
      ts_in[1] =  S1W'(pr_ff[3]) + S1W'(pr_ff[4]) - S1W'(pr_ff[5]);
      ts_in[2] =  S1W'(pr_ff[6]) + S1W'(pr_ff[7]) - S1W'(pr_ff[8]);
      ts_in[3] =  S1W'(pr_ff[9]) + S1W'(pr_ff[10]) - S1W'(pr_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff <= qrp_pkg::MAG2_WIDTH'(unsigned'(sq_ff[0]))
                  + qrp_pkg::MAG2_WIDTH'(unsigned'(sq_ff[1]))
                  + qrp_pkg::MAG2_WIDTH'(unsigned'(sq_ff[2]))
                  + qrp_pkg::MAG2_WIDTH'(unsigned'(sq_ff[3]));
         for (int i = 0; i < 4; i++) begin
            t_ff[i]  <= ts_in[i][S1W-1:FRAC_BITS];
            qb_ff[i] <= qa_ff[i];
         end
      end
   end

   // Magnitude, while t and q wait in delay lines.
   logic [NS-1:0] mag;

   qrp_isqrt u_isqrt (
      .clock  (clock),
      .en     (en),
      .rad_i  (mag2_ff),
      .root_o (mag)
   );

   logic signed [TW-1:0] tdl_ff [TD][4];
   logic signed [QW-1:0] qdl_ff [NS][4];
   logic                 zdl_ff [DS];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            tdl_ff[0][i] <= t_ff[i];
            qdl_ff[0][i] <= qb_ff[i];
            for (int j = 1; j < TD; j++) tdl_ff[j][i] <= tdl_ff[j-1][i];
            for (int j = 1; j < NS; j++) qdl_ff[j][i] <= qdl_ff[j-1][i];
         end
         zdl_ff[0] <= (mag == '0);
         for (int j = 1; j < DS; j++) zdl_ff[j] <= zdl_ff[j-1];
      end
   end

   // Inverse: x, y, z take the conjugate sign, w keeps its own.
   logic signed [IW-1:0] inv [4];

   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_div
         logic signed [QW-1:0] qc;
         logic [QW-1:0]        qabs;
         logic                 neg;
         assign qc   = qdl_ff[NS-1][g];
         assign qabs = qc[QW-1] ? QW'(-qc) : QW'(qc);
         assign neg  = (g == 3) ? qc[QW-1] : !qc[QW-1];

         qrp_div_lane #(
            .FRAC_BITS (FRAC_BITS)
         ) u_div (
            .clock  (clock),
            .en     (en),
            .mag_i  (mag),
            .num_i  (qabs),
            .neg_i  (neg),
            .quot_o (inv[g])
         );
      end
   endgenerate

   // Stage C: products of t * inv. Index 0 is w, 1..3 are x, y, z for t;
   // inv holds x, y, z, w at 0..3.
   logic signed [TW-1:0] tw, tx, ty, tz;
   logic signed [P2W-1:0] rp_ff [12];
   logic                  zc_ff;

   assign tw = tdl_ff[TD-1][0];
   assign tx = tdl_ff[TD-1][1];
   assign ty = tdl_ff[TD-1][2];
   assign tz = tdl_ff[TD-1][3];

   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff[0]  <= tx * inv[3];
         rp_ff[1]  <= tw * inv[0];
         rp_ff[2]  <= ty * inv[2];
         rp_ff[3]  <= tz * inv[1];
         rp_ff[4]  <= ty * inv[3];
         rp_ff[5]  <= tw * inv[1];
         rp_ff[6]  <= tz * inv[0];
         rp_ff[7]  <= tx * inv[2];
         rp_ff[8]  <= tz * inv[3];
         rp_ff[9]  <= tw * inv[2];
         rp_ff[10] <= tx * inv[1];
         rp_ff[11] <= ty * inv[0];
         zc_ff <= zdl_ff[DS-1];
      end
   end

   // Stage D: sums, floor shift, clipping or zeroing for a zero quaternion, output register.
   logic signed [S2W-1:0] rs_in [3];
   logic signed [S2W-1:0] rsh   [3];
   logic [PW-1:0]         rot_in [3];
   logic                  sat_in;
   logic [PW-1:0]         rot_ff [3];
   logic                  sat_ff;
   logic                  zq_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rs_in[i] = S2W'(rp_ff[4*i]) + S2W'(rp_ff[4*i+1])
                  + S2W'(rp_ff[4*i+2]) - S2W'(rp_ff[4*i+3]);
         rsh[i] = rs_in[i] >>> FRAC_BITS;
         if (zc_ff) begin
            rot_in[i] = '0;
         end else if (rsh[i] > RHI) begin
            rot_in[i] = RHI[PW-1:0];
            sat_in    = 1'b1;
         end else if (rsh[i] < RLO) begin
            rot_in[i] = RLO[PW-1:0];
            sat_in    = 1'b1;
         end else begin
            rot_in[i] = rsh[i][PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) rot_ff[i] <= rot_in[i];
         sat_ff <= sat_in;
         zq_ff  <= zc_ff;
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = RSP_W'({rot_ff[2], rot_ff[1], rot_ff[0]});
   assign rsp_tuser  = {zq_ff, sat_ff};

endmodule
